// ===== src/pcomp_pkg.sv =====
// Shared types, constants and register codes for the pressure and temperature compensation block.
`timescale 1ns / 1ps

package pcomp_pkg;

  // Configuration register map.
  localparam int NUM_TRIM_REGS = 6;
  localparam int REG_IDX_W     = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_T1_T2 = 3'd0,
    REG_T3_P1 = 3'd1,
    REG_P2_P3 = 3'd2,
    REG_P4_P5 = 3'd3,
    REG_P6_P7 = 3'd4,
    REG_P8_P9 = 3'd5
  } reg_idx_t;

  // Formula constants.
  localparam logic [26:0] T_FINE_OFFSET = 27'd128000;
  localparam logic [20:0] P_RAW_BASE    = 21'd1048576;
  localparam logic [11:0] P_SCALE       = 12'd3125;
  localparam logic [29:0] T_ROUND       = 30'd128;
  localparam int          P_BIAS_SHIFT  = 47;
  localparam logic [63:0] P_BIAS        = 64'd1 << P_BIAS_SHIFT;

  // Quotient width of the pressure division.
  localparam int DIV_BITS = 64;

  localparam logic signed [15:0] TEMP_MIN = 16'sh8000;
  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;

  // Unpacked trim words.
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } trims_t;

  // Front end to divider.
  typedef struct packed {
    logic        [63:0] num;
    logic signed [30:0] den;
    logic signed [15:0] temp;
  } front_out_t;

  // Divider to back end.
  typedef struct packed {
    logic        [63:0] quo;
    logic               pvalid;
    logic signed [15:0] temp;
  } div_out_t;

  // One finished result.
  typedef struct packed {
    logic signed [15:0] temp;
    logic        [31:0] press;
    logic               pvalid;
  } result_t;

endpackage

// ===== src/pcomp_ifs.sv =====
// Handshake channel interfaces for samples, results and configuration writes.
`timescale 1ns / 1ps

interface pcomp_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface pcomp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centideg;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;

  modport source (output valid, temp_centideg, pressure_q24_8, pressure_valid,
                  input ready);
  modport sink   (input valid, temp_centideg, pressure_q24_8, pressure_valid,
                  output ready);
endinterface

interface pcomp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcomp_pkg::REG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pressure_temp_compensation_top.sv =====
// Top level of the pipelined pressure and temperature compensation block.
// Throughput: one sample beat per cycle unless a held result stalls the pipeline;
// the 64-stage divider sets the depth.
// The whole pipeline shares one advance enable; a result waiting at the output
// register still lets new samples in until the last pipeline stage is occupied.
// Reset (synchronous, active high) clears all valid bits and sets every trim word to zero.
`timescale 1ns / 1ps

module pressure_temp_compensation_top (
  input  logic               clk,
  input  logic               rst,
  pcomp_in_if.sink           sample,
  pcomp_out_if.source        result,
  pcomp_cfg_if.sink          cfg
);

  // Trim registers. Writes must arrive only while the pipeline is empty, which the
  // block does not enforce; the stages read the trims directly instead of carrying them along.
  logic [31:0] trim_reg [0:pcomp_pkg::NUM_TRIM_REGS-1];
  pcomp_pkg::trims_t trims;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcomp_pkg::NUM_TRIM_REGS; i++) begin
        trim_reg[i] <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.index)
        pcomp_pkg::REG_T1_T2: trim_reg[0] <= cfg.data;
        pcomp_pkg::REG_T3_P1: trim_reg[1] <= cfg.data;
        pcomp_pkg::REG_P2_P3: trim_reg[2] <= cfg.data;
        pcomp_pkg::REG_P4_P5: trim_reg[3] <= cfg.data;
        pcomp_pkg::REG_P6_P7: trim_reg[4] <= cfg.data;
        pcomp_pkg::REG_P8_P9: trim_reg[5] <= cfg.data;
        default: ;
      endcase
    end
  end

  assign trims.t1 = trim_reg[0][15:0];
  assign trims.t2 = trim_reg[0][31:16];
  assign trims.t3 = trim_reg[1][15:0];
  assign trims.p1 = trim_reg[1][31:16];
  assign trims.p2 = trim_reg[2][15:0];
  assign trims.p3 = trim_reg[2][31:16];
  assign trims.p4 = trim_reg[3][15:0];
  assign trims.p5 = trim_reg[3][31:16];
  assign trims.p6 = trim_reg[4][15:0];
  assign trims.p7 = trim_reg[4][31:16];
  assign trims.p8 = trim_reg[5][15:0];
  assign trims.p9 = trim_reg[5][31:16];

  // Pipeline advance. The last pipeline stage may move whenever it is empty
  // or the output register is free or being drained this cycle.
  logic                  en;
  logic                  front_valid, div_valid, post_valid;
  pcomp_pkg::front_out_t front_data;
  pcomp_pkg::div_out_t   div_data;
  pcomp_pkg::result_t    post_data;

  assign en           = !post_valid || !result.valid || result.ready;
  assign sample.ready = en;

  pcomp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .raw_t     (sample.raw_temperature),
    .raw_p     (sample.raw_pressure),
    .trims     (trims),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  pcomp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  pcomp_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .trims     (trims),
    .out_valid (post_valid),
    .out_data  (post_data)
  );

  // Output register. It separates the result beat from the pipeline, so a
  // held result does not stop samples from entering until the last stage is occupied.
  logic out_load;

  assign out_load = post_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.temp_centideg  <= post_data.temp;
      result.pressure_q24_8 <= post_data.press;
      result.pressure_valid <= post_data.pvalid;
    end
  end

  // A skipped pressure must always read as zero.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.pressure_valid |-> result.pressure_q24_8 == '0)
    else $error("pressure not zero on a skipped result");

  // An empty last stage never blocks the input.
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !post_valid |-> sample.ready)
    else $error("input stalled with an empty last stage");

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  // A loaded output register holds a beat on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result.valid)
    else $error("loaded result not presented");

endmodule

// ===== src/pcomp_front.sv =====
// Front end: fine temperature, saturated temperature, pressure numerator and divisor.
`timescale 1ns / 1ps

module pcomp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [19:0]           raw_t,
  input  logic [19:0]           raw_p,
  input  pcomp_pkg::trims_t     trims,
  output logic                  out_valid,
  output pcomp_pkg::front_out_t out_data
);

  logic [10:1] vld;

  // Stage 1
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] m1_c, sq2_c;
  logic signed [33:0] s1_m1, s1_sq;
  logic        [20:0] s1_pd;

  assign d1    = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, trims.t1, 1'b0});
  assign d2    = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, trims.t1});
  assign m1_c  = d1 * trims.t2;
  assign sq2_c = d2 * d2;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1 <= m1_c;
      s1_sq <= sq2_c;
      s1_pd <= pcomp_pkg::P_RAW_BASE - {1'b0, raw_p};
    end
  end

  // Stage 2
  logic signed [38:0] m3_c;
  logic signed [22:0] s2_v1;
  logic signed [38:0] s2_m3;
  logic        [20:0] s2_pd;

  assign m3_c = $signed(s1_sq[33:12]) * trims.t3;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v1 <= s1_m1[33:11];
      s2_m3 <= m3_c;
      s2_pd <= s1_pd;
    end
  end

  // Stage 3
  logic signed [25:0] fine_c;
  logic signed [26:0] a_c;
  logic signed [25:0] s3_fine;
  logic signed [26:0] s3_a;
  logic        [20:0] s3_pd;

  assign fine_c = {{3{s2_v1[22]}}, s2_v1} + {s2_m3[38], s2_m3[38:14]};
  assign a_c    = {fine_c[25], fine_c} - $signed(pcomp_pkg::T_FINE_OFFSET);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fine <= fine_c;
      s3_a    <= a_c;
      s3_pd   <= s2_pd;
    end
  end

  // Stage 4
  logic signed [29:0] t5;
  logic signed [21:0] tq;
  logic signed [15:0] temp_c;
  logic signed [53:0] sq_c;
  logic signed [42:0] ap5_c, ap2_c;
  logic signed [15:0] s4_temp;
  logic        [51:0] s4_sq;
  logic signed [42:0] s4_ap5, s4_ap2;
  logic        [20:0] s4_pd;

  assign t5 = {{2{s3_fine[25]}}, s3_fine, 2'b00} + {{4{s3_fine[25]}}, s3_fine}
            + $signed(pcomp_pkg::T_ROUND);
  assign tq = t5[29:8];

  always_comb begin
    if (tq[21] && !(&tq[20:15])) begin
      temp_c = pcomp_pkg::TEMP_MIN;
    end else if (!tq[21] && (|tq[20:15])) begin
      temp_c = pcomp_pkg::TEMP_MAX;
    end else begin
      temp_c = tq[15:0];
    end
  end

  assign sq_c  = s3_a * s3_a;
  assign ap5_c = s3_a * trims.p5;
  assign ap2_c = s3_a * trims.p2;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_temp <= temp_c;
      s4_sq   <= sq_c[51:0];
      s4_ap5  <= ap5_c;
      s4_ap2  <= ap2_c;
      s4_pd   <= s3_pd;
    end
  end

  // Stage 5: square times trims six and three, split in two halves
  logic signed [42:0] hp6_c, lp6_c, hp3_c, lp3_c;
  logic signed [42:0] s5_hp6, s5_lp6, s5_hp3, s5_lp3, s5_ap5, s5_ap2;
  logic signed [15:0] s5_temp;
  logic        [20:0] s5_pd;

  assign hp6_c = $signed({1'b0, s4_sq[51:26]}) * trims.p6;
  assign lp6_c = $signed({1'b0, s4_sq[25:0]})  * trims.p6;
  assign hp3_c = $signed({1'b0, s4_sq[51:26]}) * trims.p3;
  assign lp3_c = $signed({1'b0, s4_sq[25:0]})  * trims.p3;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hp6  <= hp6_c;
      s5_lp6  <= lp6_c;
      s5_hp3  <= hp3_c;
      s5_lp3  <= lp3_c;
      s5_ap5  <= s4_ap5;
      s5_ap2  <= s4_ap2;
      s5_temp <= s4_temp;
      s5_pd   <= s4_pd;
    end
  end

  // Stage 6
  logic [63:0] b6_c, b3_c, bk_c;
  logic [63:0] s6_b6, s6_b3, s6_bk;
  logic signed [42:0] s6_ap2;
  logic signed [15:0] s6_temp;
  logic        [20:0] s6_pd;

  assign b6_c = {s5_hp6[37:0], 26'd0} + {{21{s5_lp6[42]}}, s5_lp6};
  assign b3_c = {s5_hp3[37:0], 26'd0} + {{21{s5_lp3[42]}}, s5_lp3};
  assign bk_c = {{4{s5_ap5[42]}}, s5_ap5, 17'd0} + {{13{trims.p4[15]}}, trims.p4, 35'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      s6_b6   <= b6_c;
      s6_b3   <= b3_c;
      s6_bk   <= bk_c;
      s6_ap2  <= s5_ap2;
      s6_temp <= s5_temp;
      s6_pd   <= s5_pd;
    end
  end

  // Stage 7
  logic [63:0] s7_b, s7_a2;
  logic signed [15:0] s7_temp;
  logic        [20:0] s7_pd;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b    <= s6_b6 + s6_bk;
      s7_a2   <= {{8{s6_b3[63]}}, s6_b3[63:8]} + {{9{s6_ap2[42]}}, s6_ap2, 12'd0};
      s7_temp <= s6_temp;
      s7_pd   <= s6_pd;
    end
  end

  // Stage 8
  logic [63:0] s8_x, s8_n0;
  logic signed [15:0] s8_temp;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_x    <= s7_a2 + pcomp_pkg::P_BIAS;
      s8_n0   <= {12'd0, s7_pd, 31'd0} - s7_b;
      s8_temp <= s7_temp;
    end
  end

  // Stage 9: 64-bit by narrow products as two partial products each
  logic [47:0] xl_c, xh_c;
  logic [43:0] nl_c, nh_c;
  logic [47:0] s9_xl;
  logic [31:0] s9_xh;
  logic [43:0] s9_nl;
  logic [31:0] s9_nh;
  logic signed [15:0] s9_temp;

  assign xl_c = s8_x[31:0]  * trims.p1;
  assign xh_c = s8_x[63:32] * trims.p1;
  assign nl_c = s8_n0[31:0]  * pcomp_pkg::P_SCALE;
  assign nh_c = s8_n0[63:32] * pcomp_pkg::P_SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_xl   <= xl_c;
      s9_xh   <= xh_c[31:0];
      s9_nl   <= nl_c;
      s9_nh   <= nh_c[31:0];
      s9_temp <= s8_temp;
    end
  end

  // Stage 10
  logic [63:0] den_full;

  assign den_full = {s9_xh, 32'd0} + {16'd0, s9_xl};

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.num  <= {s9_nh, 32'd0} + {20'd0, s9_nl};
      out_data.den  <= den_full[63:33];
      out_data.temp <= s9_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_valid};
    end
  end

  assign out_valid = vld[10];

endmodule

// ===== src/pcomp_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`timescale 1ns / 1ps

module pcomp_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  pcomp_pkg::front_out_t in_data,
  output logic                  out_valid,
  output pcomp_pkg::div_out_t   out_data
);

  localparam int N = pcomp_pkg::DIV_BITS;

  typedef struct packed {
    logic [30:0]        rem;
    logic [N-1:0]       bits;
    logic [30:0]        mag;
    logic               qneg;
    logic               pvalid;
    logic signed [15:0] temp;
  } div_stage_t;

  div_stage_t stg [0:N];
  logic [N+1:0] vld;

  // Setup: magnitudes and sign of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].rem    <= '0;
      stg[0].bits   <= in_data.num[N-1] ? (N'(0) - in_data.num) : in_data.num;
      stg[0].mag    <= in_data.den[30] ? (31'd0 - 31'(in_data.den)) : 31'(in_data.den);
      stg[0].qneg   <= in_data.num[N-1] ^ in_data.den[30];
      stg[0].pvalid <= (in_data.den != '0);
      stg[0].temp   <= in_data.temp;
    end
  end

  // Restoring division; the quotient bits fill in from the bottom as the
  // dividend bits leave from the top.
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;

    assign trial = {stg[k].rem, stg[k].bits[N-1]};
    assign ge    = (trial >= {1'b0, stg[k].mag});

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1].rem    <= ge ? 31'(trial - {1'b0, stg[k].mag}) : trial[30:0];
        stg[k+1].bits   <= {stg[k].bits[N-2:0], ge};
        stg[k+1].mag    <= stg[k].mag;
        stg[k+1].qneg   <= stg[k].qneg;
        stg[k+1].pvalid <= stg[k].pvalid;
        stg[k+1].temp   <= stg[k].temp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.quo    <= stg[N].qneg ? (N'(0) - stg[N].bits) : stg[N].bits;
      out_data.pvalid <= stg[N].pvalid;
      out_data.temp   <= stg[N].temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N:0], in_valid};
    end
  end

  assign out_valid = vld[N+1];

endmodule

// ===== src/pcomp_post.sv =====
// Back end: second-order pressure correction, offset and saturation.
`timescale 1ns / 1ps

module pcomp_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pcomp_pkg::div_out_t in_data,
  input  pcomp_pkg::trims_t   trims,
  output logic                out_valid,
  output pcomp_pkg::result_t  out_data
);

  logic [6:1] vld;

  // Stage 1
  logic [63:0] ph;
  logic [63:0] ll_c, lh_c;
  logic signed [48:0] l8_c;
  logic signed [47:0] h8_c;
  logic [63:0] s1_p, s1_ll;
  logic [31:0] s1_lh, s1_h8;
  logic signed [48:0] s1_l8;
  logic        s1_pv;
  logic signed [15:0] s1_temp;

  assign ph   = {{13{in_data.quo[63]}}, in_data.quo[63:13]};
  assign ll_c = ph[31:0] * ph[31:0];
  assign lh_c = ph[31:0] * ph[63:32];
  assign l8_c = $signed({1'b0, in_data.quo[31:0]}) * trims.p8;
  assign h8_c = $signed(in_data.quo[63:32]) * trims.p8;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p    <= in_data.quo;
      s1_ll   <= ll_c;
      s1_lh   <= lh_c[31:0];
      s1_l8   <= l8_c;
      s1_h8   <= h8_c[31:0];
      s1_pv   <= in_data.pvalid;
      s1_temp <= in_data.temp;
    end
  end

  // Stage 2
  logic [63:0] c2_full;
  logic [63:0] s2_sq, s2_c2, s2_p;
  logic        s2_pv;
  logic signed [15:0] s2_temp;

  assign c2_full = {{15{s1_l8[48]}}, s1_l8} + {s1_h8, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq   <= s1_ll + {s1_lh[30:0], 33'd0};
      s2_c2   <= {{19{c2_full[63]}}, c2_full[63:19]};
      s2_p    <= s1_p;
      s2_pv   <= s1_pv;
      s2_temp <= s1_temp;
    end
  end

  // Stage 3
  logic signed [48:0] l9_c;
  logic signed [47:0] h9_c;
  logic signed [48:0] s3_l9;
  logic [31:0] s3_h9;
  logic [63:0] s3_pc2;
  logic        s3_pv;
  logic signed [15:0] s3_temp;

  assign l9_c = $signed({1'b0, s2_sq[31:0]}) * trims.p9;
  assign h9_c = $signed(s2_sq[63:32]) * trims.p9;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_l9   <= l9_c;
      s3_h9   <= h9_c[31:0];
      s3_pc2  <= s2_p + s2_c2;
      s3_pv   <= s2_pv;
      s3_temp <= s2_temp;
    end
  end

  // Stage 4
  logic [63:0] c1_full;
  logic [63:0] s4_c1, s4_pc2;
  logic        s4_pv;
  logic signed [15:0] s4_temp;

  assign c1_full = {{15{s3_l9[48]}}, s3_l9} + {s3_h9, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c1   <= {{25{c1_full[63]}}, c1_full[63:25]};
      s4_pc2  <= s3_pc2;
      s4_pv   <= s3_pv;
      s4_temp <= s3_temp;
    end
  end

  // Stage 5
  logic [63:0] s5_sum;
  logic        s5_pv;
  logic signed [15:0] s5_temp;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sum  <= s4_pc2 + s4_c1;
      s5_pv   <= s4_pv;
      s5_temp <= s4_temp;
    end
  end

  // Stage 6: offset by trim seven, then clamp to the unsigned 32-bit range; a skipped pressure reads as zero.
  logic [63:0] fin;
  logic [31:0] press_c;

  assign fin = {{8{s5_sum[63]}}, s5_sum[63:8]} + {{44{trims.p7[15]}}, trims.p7, 4'd0};

  always_comb begin
    if (!s5_pv || fin[63]) begin
      press_c = '0;
    end else if (|fin[62:32]) begin
      press_c = '1;
    end else begin
      press_c = fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.temp   <= s5_temp;
      out_data.press  <= press_c;
      out_data.pvalid <= s5_pv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:1], in_valid};
    end
  end

  assign out_valid = vld[6];

endmodule
